// ===== sv/elapsed_date_difference_defines.svh =====
// Assertion macros for the elapsed date difference block.
// Used by elapsed_date_difference.sv; expects a clock clk and a reset rst in scope.
`ifndef ELAPSED_DATE_DIFFERENCE_DEFINES_SVH
`define ELAPSED_DATE_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/edd_pkg.sv =====
// Types, constants and calendar tables for the elapsed date difference block.
// No dependencies; used by elapsed_date_difference.sv.
package edd_pkg;

  localparam int YEAR_BITS   = 14;
  localparam int MONTH_BITS  = 4;
  localparam int DAY_BITS    = 5;
  localparam int DAYS_BITS   = 22;
  localparam int MONTHS_BITS = 17;
  localparam int YEARS_BITS  = 14;

  localparam logic [YEAR_BITS-1:0]  MAX_YEAR   = YEAR_BITS'(9999);
  localparam logic [MONTH_BITS-1:0] MAX_MONTH  = MONTH_BITS'(12);
  localparam logic [MONTH_BITS-1:0] FEBRUARY   = MONTH_BITS'(2);

  // floor(x / 100) = (x * RECIP_100) >> SHIFT_100 for every x below 2**YEAR_BITS.
  localparam int RECIP_100 = 10486;
  localparam int SHIFT_100 = 20;
  // floor(x / 12) = (x * RECIP_12) >> SHIFT_12 for every x below 2**MONTHS_BITS.
  localparam int RECIP_12  = 174763;
  localparam int SHIFT_12  = 21;

  typedef struct packed {
    logic [YEAR_BITS-1:0]  later_year;
    logic [MONTH_BITS-1:0] later_month;
    logic [DAY_BITS-1:0]   later_day;
    logic [YEAR_BITS-1:0]  earlier_year;
    logic [MONTH_BITS-1:0] earlier_month;
    logic [DAY_BITS-1:0]   earlier_day;
  } dates_t;

  typedef struct packed {
    logic [DAYS_BITS-1:0]   elapsed_days;
    logic [MONTHS_BITS-1:0] elapsed_months;
    logic [YEARS_BITS-1:0]  elapsed_years;
    logic                   same_month_day;
    logic                   bad_input;
  } result_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_BITS-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Common-year month lengths; months out of range give zero.
  function automatic logic [DAY_BITS-1:0] month_length(input logic [MONTH_BITS-1:0] m);
    logic [DAY_BITS-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Leap test given the year and its quotient by 100.
  function automatic logic is_leap(input logic [YEAR_BITS-1:0] y, input logic [7:0] q100);
    logic [YEAR_BITS-1:0] r100;
    r100 = y - YEAR_BITS'({6'd0, q100} * 14'd100);
    return ((y[1:0] == 2'b00) && (r100 != '0)) || ((r100 == '0) && (q100[1:0] == 2'b00));
  endfunction

endpackage

// ===== sv/elapsed_date_difference.sv =====
// Top level of the elapsed date difference block: a four-stage pipeline with a
// two-entry output buffer. Depends on edd_pkg and elapsed_date_difference_defines.svh.

// Takes one pair of Gregorian dates per clock while dates_stall is low and returns,
// through stages 1 to 4 and then the output register, the days, completed months
// and completed years between them. Throughput is one word per unstalled cycle, set
// by the four register stages (reciprocal multiplies, leap and range checks, day-number
// sums, compare and year divide) that all advance together. The output register is
// backed by a skid register, so dates_stall is a registered signal and rises only
// once both are full; the pipeline then holds until the result side takes a word.
// There is no state beyond the pipeline, and reset needs no clearing pass.
`include "elapsed_date_difference_defines.svh"

module elapsed_date_difference (
  input  logic             clk,
  input  logic             rst,
  input  logic             dates_valid,
  output logic             dates_stall,
  input  edd_pkg::dates_t  dates,
  output logic             result_valid,
  input  logic             result_stall,
  output edd_pkg::result_t result
);

  localparam int YB = edd_pkg::YEAR_BITS;
  localparam int DB = edd_pkg::DAYS_BITS;
  localparam int MB = edd_pkg::MONTHS_BITS;
  localparam int YM_BITS = MB + 1;

  logic v1, v2, v3, v4;
  logic skid_valid;
  edd_pkg::result_t skid;
  logic en, take;

  assign en          = !skid_valid;
  assign take        = result_valid && !result_stall;
  assign dates_stall = skid_valid;

  // Stage 1: reciprocal multiplies for the divisions by 100, and 365 * (year - 1).
  logic [YB-1:0] s1_ly, s1_ey;
  logic [3:0]    s1_lm, s1_em;
  logic [4:0]    s1_ld, s1_ed;
  logic [7:0]    s1_qy_l, s1_qy_e, s1_qp_l, s1_qp_e;
  logic [DB-1:0] s1_p365_l, s1_p365_e;
  logic [YM_BITS-1:0] s1_ym_l, s1_ym_e;
  logic          s1_same, s1_dlt;

  logic [YB-1:0] p_l_c, p_e_c;
  logic [27:0]   qy_l_prod, qy_e_prod, qp_l_prod, qp_e_prod;

  always_comb begin
    p_l_c     = dates.later_year - YB'(1);
    p_e_c     = dates.earlier_year - YB'(1);
    qy_l_prod = 28'(dates.later_year) * 28'(edd_pkg::RECIP_100);
    qy_e_prod = 28'(dates.earlier_year) * 28'(edd_pkg::RECIP_100);
    qp_l_prod = 28'(p_l_c) * 28'(edd_pkg::RECIP_100);
    qp_e_prod = 28'(p_e_c) * 28'(edd_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ly     <= dates.later_year;
      s1_lm     <= dates.later_month;
      s1_ld     <= dates.later_day;
      s1_ey     <= dates.earlier_year;
      s1_em     <= dates.earlier_month;
      s1_ed     <= dates.earlier_day;
      s1_qy_l   <= qy_l_prod[edd_pkg::SHIFT_100 +: 8];
      s1_qy_e   <= qy_e_prod[edd_pkg::SHIFT_100 +: 8];
      s1_qp_l   <= qp_l_prod[edd_pkg::SHIFT_100 +: 8];
      s1_qp_e   <= qp_e_prod[edd_pkg::SHIFT_100 +: 8];
      s1_p365_l <= DB'(p_l_c) * DB'(365);
      s1_p365_e <= DB'(p_e_c) * DB'(365);
      s1_ym_l   <= YM_BITS'(dates.later_year) * YM_BITS'(12) + YM_BITS'(dates.later_month);
      s1_ym_e   <= YM_BITS'(dates.earlier_year) * YM_BITS'(12)
                   + YM_BITS'(dates.earlier_month);
      s1_same   <= (dates.later_month == dates.earlier_month)
                   && (dates.later_day == dates.earlier_day);
      s1_dlt    <= dates.later_day < dates.earlier_day;
    end
  end

  // Stage 2: leap years, range checks, and the two halves of each day number.
  logic          s2_ok_l, s2_ok_e, s2_same;
  logic [DB-1:0] s2_na_l, s2_na_e;
  logic [8:0]    s2_doy_l, s2_doy_e;
  logic [YM_BITS-1:0] s2_total;

  logic          leap_l_c, leap_e_c, ok_l_c, ok_e_c;
  logic [4:0]    len_l_c, len_e_c;
  logic [YB-1:0] pp_l_c, pp_e_c;

  always_comb begin
    leap_l_c = edd_pkg::is_leap(s1_ly, s1_qy_l);
    leap_e_c = edd_pkg::is_leap(s1_ey, s1_qy_e);
    len_l_c  = edd_pkg::month_length(s1_lm)
               + 5'((s1_lm == edd_pkg::FEBRUARY) && leap_l_c);
    len_e_c  = edd_pkg::month_length(s1_em)
               + 5'((s1_em == edd_pkg::FEBRUARY) && leap_e_c);
    ok_l_c   = (s1_ly != '0) && (s1_ly <= edd_pkg::MAX_YEAR) && (s1_lm != '0)
               && (s1_lm <= edd_pkg::MAX_MONTH) && (s1_ld != '0) && (s1_ld <= len_l_c);
    ok_e_c   = (s1_ey != '0) && (s1_ey <= edd_pkg::MAX_YEAR) && (s1_em != '0)
               && (s1_em <= edd_pkg::MAX_MONTH) && (s1_ed != '0) && (s1_ed <= len_e_c);
    pp_l_c   = s1_ly - YB'(1);
    pp_e_c   = s1_ey - YB'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok_l  <= ok_l_c;
      s2_ok_e  <= ok_e_c;
      s2_same  <= s1_same;
      s2_na_l  <= s1_p365_l + DB'(pp_l_c >> 2) - DB'(s1_qp_l) + DB'(s1_qp_l >> 2);
      s2_na_e  <= s1_p365_e + DB'(pp_e_c >> 2) - DB'(s1_qp_e) + DB'(s1_qp_e >> 2);
      s2_doy_l <= edd_pkg::days_before_month(s1_lm)
                  + 9'((s1_lm > edd_pkg::FEBRUARY) && leap_l_c) + 9'(s1_ld) - 9'd1;
      s2_doy_e <= edd_pkg::days_before_month(s1_em)
                  + 9'((s1_em > edd_pkg::FEBRUARY) && leap_e_c) + 9'(s1_ed) - 9'd1;
      s2_total <= s1_ym_l - s1_ym_e - YM_BITS'(s1_dlt);
    end
  end

  // Stage 3: full day numbers and the reciprocal multiply for months / 12.
  logic          s3_good, s3_same;
  logic [DB-1:0] s3_nl, s3_ne;
  logic [MB-1:0] s3_months;
  logic [MB+17:0] s3_yprod;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_good   <= s2_ok_l && s2_ok_e;
      s3_same   <= s2_same;
      s3_nl     <= s2_na_l + DB'(s2_doy_l);
      s3_ne     <= s2_na_e + DB'(s2_doy_e);
      s3_months <= s2_total[MB-1:0];
      s3_yprod  <= (MB+18)'(s2_total[MB-1:0]) * (MB+18)'(edd_pkg::RECIP_12);
    end
  end

  // Stage 4: order check, day difference, and zeroing of rejected words.
  edd_pkg::result_t s4;
  logic             ord_ok_c;

  assign ord_ok_c = s3_good && (s3_nl >= s3_ne);

  always_ff @(posedge clk) begin
    if (en) begin
      s4.elapsed_days   <= ord_ok_c ? s3_nl - s3_ne : '0;
      s4.elapsed_months <= ord_ok_c ? s3_months : '0;
      s4.elapsed_years  <= ord_ok_c
                           ? s3_yprod[edd_pkg::SHIFT_12 +: edd_pkg::YEARS_BITS] : '0;
      s4.same_month_day <= s3_same;
      s4.bad_input      <= !ord_ok_c;
    end
  end

  // Valid bits travel with the data; the whole pipe holds while the skid is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= dates_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Output register and skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (en) begin
      if (v4) begin
        if (!result_valid || take) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end else if (take) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v4) begin
        if (!result_valid || take) begin
          result <= s4;
        end else begin
          skid <= s4;
        end
      end
    end else if (take) begin
      result <= skid;
    end
  end

  `EDD_ASSERT_NOW(a_skid_implies_out, skid_valid, result_valid, "skid full with output empty")
  `EDD_ASSERT_NEXT(a_skid_held, skid_valid && !take, skid_valid, "skid word lost while stalled")
  `EDD_ASSERT_NEXT(a_out_drains, take && !skid_valid && !v4, !result_valid, "output word repeated")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for elapsed_date_difference: directed calendar edges and
// bad pairs, then random pairs mostly under idling on both sides. Depends on edd_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LAST_YEAR      = 9999;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;

  localparam int YEAR_W   = edd_pkg::YEAR_BITS;
  localparam int MONTH_W  = edd_pkg::MONTH_BITS;
  localparam int DAY_W    = edd_pkg::DAY_BITS;
  localparam int DAYS_W   = edd_pkg::DAYS_BITS;
  localparam int MONTHS_W = edd_pkg::MONTHS_BITS;
  localparam int YEARS_W  = edd_pkg::YEARS_BITS;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             dates_valid  = 1'b0;
  logic             dates_stall;
  edd_pkg::dates_t  dates        = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  edd_pkg::result_t result;

  edd_pkg::result_t pending_results[$];
  bit      idle_enable     = 1'b1;
  int      fail_count      = 0;
  int      words_sent      = 0;
  int      results_checked = 0;
  int      flagged_results = 0;
  int      stall_left      = 0;
  int      quiet_cycles    = 0;

  elapsed_date_difference dut (
    .clk          (clk),
    .rst          (rst),
    .dates_valid  (dates_valid),
    .dates_stall  (dates_stall),
    .dates        (dates),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #4 clk = ~clk;

  // Calendar arithmetic for the expected results.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    return (y >= 1) && (y <= LAST_YEAR) && (d >= 1) && (d <= month_days(y, m));
  endfunction

  // Day 0 is January 1 of year 1.
  function automatic int unsigned day_index(int unsigned y, int unsigned m, int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic edd_pkg::result_t predict_elapsed(edd_pkg::dates_t w);
    edd_pkg::result_t r;
    int unsigned      ly, lm, ld, ey, em, ed, nl, ne, months;
    ly = w.later_year;
    lm = w.later_month;
    ld = w.later_day;
    ey = w.earlier_year;
    em = w.earlier_month;
    ed = w.earlier_day;
    r = '0;
    r.same_month_day = (lm == em) && (ld == ed);
    r.bad_input = 1'b1;
    if (date_valid(ly, lm, ld) && date_valid(ey, em, ed)) begin
      nl = day_index(ly, lm, ld);
      ne = day_index(ey, em, ed);
      if (nl >= ne) begin
        // A month only counts once the later day of month reaches the earlier one.
        months = ly * 12 + lm - (ey * 12 + em) - ((ld < ed) ? 1 : 0);
        r.bad_input      = 1'b0;
        r.elapsed_days   = DAYS_W'(nl - ne);
        r.elapsed_months = MONTHS_W'(months);
        r.elapsed_years  = YEARS_W'(months / 12);
      end
    end
    return r;
  endfunction

  function automatic edd_pkg::dates_t make_dates(int unsigned ly, int unsigned lm,
                                                 int unsigned ld, int unsigned ey,
                                                 int unsigned em, int unsigned ed);
    edd_pkg::dates_t w;
    w.later_year    = YEAR_W'(ly);
    w.later_month   = MONTH_W'(lm);
    w.later_day     = DAY_W'(ld);
    w.earlier_year  = YEAR_W'(ey);
    w.earlier_month = MONTH_W'(em);
    w.earlier_day   = DAY_W'(ed);
    return w;
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 12);
      1:       return $urandom_range(LAST_YEAR - 11, LAST_YEAR);
      2:       return 100 * $urandom_range(15, 25) + $urandom_range(0, 4);
      default: return $urandom_range(1, LAST_YEAR);
    endcase
  endfunction

  // Mostly ordered valid pairs near each other, some reversed, some with one
  // field broken, and some pure noise across every bit.
  function automatic edd_pkg::dates_t random_dates();
    int unsigned     ly, lm, ld, ey, em, ed, pick, tmp;
    edd_pkg::dates_t w;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.later_year    = YEAR_W'($urandom);
      w.later_month   = MONTH_W'($urandom);
      w.later_day     = DAY_W'($urandom);
      w.earlier_year  = YEAR_W'($urandom);
      w.earlier_month = MONTH_W'($urandom);
      w.earlier_day   = DAY_W'($urandom);
      return w;
    end
    ly = pick_year();
    case ($urandom_range(0, 3))
      0:       ey = ly;
      1:       ey = (ly > 3) ? ly - $urandom_range(0, 3) : 1;
      2:       ey = $urandom_range(1, LAST_YEAR);
      default: ey = pick_year();
    endcase
    lm = $urandom_range(1, 12);
    em = $urandom_range(0, 1) ? lm : $urandom_range(1, 12);
    ld = $urandom_range(1, month_days(ly, lm));
    case ($urandom_range(0, 2))
      0:       ed = (ld < month_days(ey, em)) ? ld : month_days(ey, em);
      1:       ed = (ld + 1 <= month_days(ey, em)) ? ld + 1 : 1;
      default: ed = $urandom_range(1, month_days(ey, em));
    endcase
    if (pick < 80 && day_index(ly, lm, ld) < day_index(ey, em, ed)) begin
      tmp = ly; ly = ey; ey = tmp;
      tmp = lm; lm = em; em = tmp;
      tmp = ld; ld = ed; ed = tmp;
    end
    if (pick >= 90) begin
      case ($urandom_range(0, 3))
        0:       ld = month_days(ly, lm) + 1;
        1:       em = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
        2:       ey = $urandom_range(0, 1) ? 0 : $urandom_range(LAST_YEAR + 1, 16383);
        default: begin
          ly = 4 * $urandom_range(1, 2499) + 1;
          lm = 2;
          ld = 29;
        end
      endcase
    end
    return make_dates(ly, lm, ld, ey, em, ed);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("  mismatch in result %0d: %s got %0d, expected %0d",
             results_checked, what, got, want);
    fail_count++;
  endtask

  // Holds valid until the word is taken, with an optional idle burst before it.
  task automatic send_dates(edd_pkg::dates_t w);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      dates_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    dates_valid <= 1'b1;
    dates       <= w;
    @(posedge clk);
    while (dates_stall) @(posedge clk);
    pending_results.push_back(predict_elapsed(w));
    words_sent++;
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    result_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin : check_results
    edd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (result.elapsed_days !== want.elapsed_days)
          report_mismatch("elapsed_days", result.elapsed_days, want.elapsed_days);
        if (result.elapsed_months !== want.elapsed_months)
          report_mismatch("elapsed_months", result.elapsed_months, want.elapsed_months);
        if (result.elapsed_years !== want.elapsed_years)
          report_mismatch("elapsed_years", result.elapsed_years, want.elapsed_years);
        if (result.same_month_day !== want.same_month_day)
          report_mismatch("same_month_day", result.same_month_day, want.same_month_day);
        if (result.bad_input !== want.bad_input)
          report_mismatch("bad_input", result.bad_input, want.bad_input);
        if (want.bad_input) flagged_results++;
      end
      results_checked++;
    end
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (dates_valid && !dates_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("  timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[elapsed_date_difference] ERROR");
        $finish;
      end
    end
  end

  task automatic test_calendar_edges();
    send_dates(make_dates(2024, 5, 17, 2024, 5, 17));
    send_dates(make_dates(LAST_YEAR, 12, 31, 1, 1, 1));
    send_dates(make_dates(1, 1, 1, 1, 1, 1));
    send_dates(make_dates(2000, 2, 29, 1996, 2, 29));
    send_dates(make_dates(2024, 3, 1, 2024, 2, 29));
    send_dates(make_dates(2100, 3, 1, 2100, 2, 28));
    send_dates(make_dates(2023, 3, 14, 2020, 3, 15));
    send_dates(make_dates(2023, 1, 5, 2022, 12, 5));
    send_dates(make_dates(2023, 12, 31, 2022, 1, 1));
    send_dates(make_dates(LAST_YEAR, 12, 31, LAST_YEAR, 12, 30));
    send_dates(make_dates(1, 12, 31, 1, 1, 1));
  endtask

  task automatic test_invalid_and_order();
    send_dates(make_dates(2023, 6, 15, 2024, 6, 15));
    send_dates(make_dates(2023, 6, 15, 2023, 6, 16));
    send_dates(make_dates(1900, 2, 29, 1800, 1, 1));
    send_dates(make_dates(0, 1, 1, 1, 1, 1));
    send_dates(make_dates(LAST_YEAR + 1, 1, 1, 1, 1, 1));
    send_dates(make_dates(16383, 15, 31, 16383, 15, 31));
    send_dates(make_dates(2023, 0, 10, 2020, 1, 1));
    send_dates(make_dates(2023, 5, 10, 2020, 13, 1));
    send_dates(make_dates(2023, 5, 10, 2020, 5, 0));
    send_dates(make_dates(2023, 4, 31, 2020, 1, 1));
    send_dates(make_dates(2023, 2, 29, 2020, 1, 1));
  endtask

  // Random pairs in blocks, each block with or without idling, and one
  // pause in the middle until every result has come back.
  task automatic test_random_mixed();
    for (int blk = 0; blk < 12; blk++) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 50; i++) send_dates(random_dates());
      if (blk == 5) begin
        dates_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_quiet_tail();
    idle_enable = 1'b0;
    for (int i = 0; i < 130; i++) send_dates(random_dates());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_calendar_edges();
    test_invalid_and_order();
    test_random_mixed();
    test_quiet_tail();
    dates_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("  %0d date pairs sent, %0d results checked, %0d of them flagged bad",
             words_sent, results_checked, flagged_results);
    if (fail_count == 0) begin
      $display("[elapsed_date_difference] OK");
    end else begin
      $display("[elapsed_date_difference] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/edd_pkg.sv
sv/elapsed_date_difference.sv
sim/testbench.sv
